// ----- hw/rtl/pfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfs_pkg - shared types and constants of the packet slot FIFO
// Request and response payloads, register indexes and the control groups
// that pass between the push writer, the pop sequencer and the top level.
// -----------------------------------------------------------------------------
package pfs_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 4'd1;

   localparam logic [9:0] SLOT_BYTES_RST = 10'd512;
   localparam logic [4:0] SLOT_COUNT_RST = 5'd16;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [63:0] push_data;
      logic [3:0]  push_bytes;
      logic        push_last;
      logic [9:0]  pop_limit;
   } pfs_req_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [3:0]  out_bytes;
      logic        out_last;
      logic [9:0]  moved_bytes;
      logic [4:0]  queued;
   } pfs_rsp_type;

   // end of a pushed packet: store is low when the packet was dropped
   typedef struct packed {
      logic       valid;
      logic       store;
      logic [9:0] length;
   } pfs_commit_type;

   // one word of a pop run, or the single empty word of a zero-length pop
   typedef struct packed {
      logic        valid;
      logic [63:0] data;
      logic [3:0]  bytes;
      logic        last;
      logic [9:0]  moved;
   } pfs_pop_res_type;

endpackage
`default_nettype wire

// ----- hw/rtl/pfs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfs_ram - simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
module pfs_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pfs_push.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfs_push - push writer
// Tracks the fill position of the packet being written, rotates each pushed
// word onto the byte lanes and issues one lane write per byte.
// -----------------------------------------------------------------------------
module pfs_push #(
   parameter  int SLOTS      = 16,
   parameter  int SLOT_BYTES = 512,
   parameter  int WORD_BYTES = 8,
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int ROWS  = (SLOT_BYTES + WORD_BYTES - 1) / WORD_BYTES,
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int RW1   = $clog2(ROWS + 1),
   localparam int AW    = SW + RW,
   localparam int CNT_W = $clog2(SLOTS + 1),
   localparam int LNW   = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire pfs_pkg::pfs_req_type                req,
   input  wire logic [CNT_W-1:0]                    count,
   input  wire logic [CNT_W-1:0]                    nslots,
   input  wire logic [9:0]                          limit,
   input  wire logic [SW-1:0]                       tail,
   output logic      [WORD_BYTES-1:0]               lane_we,
   output logic      [WORD_BYTES-1:0][AW-1:0]       lane_addr,
   output logic      [WORD_BYTES-1:0][7:0]          lane_data,
   output pfs_pkg::pfs_commit_type                  commit
);

   import pfs_pkg::*;

   logic                           in_packet_ff, in_packet_in;
   logic                           drop_ff, drop_in;
   logic [9:0]                     fill_ff, fill_in;
   logic [RW1-1:0]                 row_ff, row_in;
   logic [LNW-1:0]                 lane_ff, lane_in;

   logic                           first;
   logic                           drop_cur;
   logic [9:0]                     fill_cur;
   logic [9:0]                     room;
   logic [9:0]                     fill_new;
   logic [RW1-1:0]                 row_cur;
   logic [RW1-1:0]                 row_nxt;
   logic [3:0]                     lane_cur;
   logic [3:0]                     nb;
   logic [3:0]                     take;
   logic [3:0]                     lane_sum;
   logic [WORD_BYTES-1:0][3:0]     rel;
   logic [WORD_BYTES-1:0][63:0]    shifted;
   logic [WORD_BYTES-1:0][RW1-1:0] lane_row;

   always_comb begin
      first    = !in_packet_ff;
      fill_cur = first ? '0 : fill_ff;
      row_cur  = first ? '0 : row_ff;
      lane_cur = first ? '0 : 4'(lane_ff);
      // a packet that finds the ring full is dropped as a whole
      drop_cur = first ? (count >= nslots) : drop_ff;
      nb       = (req.push_bytes > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : req.push_bytes;
      room     = (fill_cur >= limit) ? '0 : limit - fill_cur;
      take     = (10'(nb) < room) ? nb : room[3:0];
      fill_new = fill_cur + 10'(take);
      lane_sum = lane_cur + take;
      row_nxt  = row_cur + RW1'(1);

      // byte lane l takes byte rel[l] of the word; lanes below the start
      // lane wrap into the next row
      for (int l = 0; l < WORD_BYTES; l++) begin
         if (4'(l) >= lane_cur) begin
            rel[l]      = 4'(l) - lane_cur;
            lane_row[l] = row_cur;
         end else begin
            rel[l]      = 4'(l) + 4'(WORD_BYTES) - lane_cur;
            lane_row[l] = row_nxt;
         end
         shifted[l]   = req.push_data >> {rel[l][2:0], 3'b000};
         lane_we[l]   = accept && !drop_cur && (rel[l] < take);
         lane_addr[l] = {tail, lane_row[l][RW-1:0]};
         lane_data[l] = shifted[l][7:0];
      end

      in_packet_in = in_packet_ff;
      drop_in      = drop_ff;
      fill_in      = fill_ff;
      row_in       = row_ff;
      lane_in      = lane_ff;
      if (accept) begin
         if (req.push_last) begin
            in_packet_in = 1'b0;
            drop_in      = 1'b0;
            fill_in      = '0;
            row_in       = '0;
            lane_in      = '0;
         end else begin
            in_packet_in = 1'b1;
            drop_in      = drop_cur;
            fill_in      = fill_new;
            if (lane_sum >= 4'(WORD_BYTES)) begin
               lane_in = LNW'(lane_sum - 4'(WORD_BYTES));
               row_in  = row_nxt;
            end else begin
               lane_in = LNW'(lane_sum);
               row_in  = row_cur;
            end
         end
      end

      commit.valid  = accept && req.push_last;
      commit.store  = !drop_cur;
      commit.length = fill_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         drop_ff      <= 1'b0;
         fill_ff      <= '0;
         row_ff       <= '0;
         lane_ff      <= '0;
      end else begin
         in_packet_ff <= in_packet_in;
         drop_ff      <= drop_in;
         fill_ff      <= fill_in;
         row_ff       <= row_in;
         lane_ff      <= lane_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/pfs_pop.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfs_pop - pop sequencer
// Reads the head slot's stored length, then streams its rows from the byte
// lanes one word per cycle, cut to the reader's limit.
// -----------------------------------------------------------------------------
module pfs_pop #(
   parameter  int SLOTS      = 16,
   parameter  int SLOT_BYTES = 512,
   parameter  int WORD_BYTES = 8,
   localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int ROWS = (SLOT_BYTES + WORD_BYTES - 1) / WORD_BYTES,
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int AW   = SW + RW
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [SW-1:0]              start_slot,
   input  wire logic [9:0]                 start_limit,
   input  wire logic [9:0]                 len_rd_data,
   input  wire logic [WORD_BYTES-1:0][7:0] lane_rd_data,
   output logic                            busy,
   output logic                            rd_en,
   output logic      [AW-1:0]              rd_addr,
   output pfs_pkg::pfs_pop_res_type        res
);

   import pfs_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LEN    = 2'd1;
   localparam logic [1:0] ST_STREAM = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [9:0]    limit_ff, limit_in;
   logic [9:0]    len_ff, len_in;
   logic [9:0]    rem_ff, rem_in;
   logic [RW-1:0] row_ff, row_in;

   logic [9:0]    len_cap;
   logic [9:0]    len_sat;
   logic [3:0]    take;
   logic          last;

   always_comb begin
      len_cap = (len_rd_data < limit_ff) ? len_rd_data : limit_ff;
      len_sat = (13'(len_cap) > 13'(SLOT_BYTES)) ? 10'(SLOT_BYTES) : len_cap;
      take    = (rem_ff < 10'(WORD_BYTES)) ? rem_ff[3:0] : 4'(WORD_BYTES);
      last    = (rem_ff <= 10'(WORD_BYTES));

      state_in = state_ff;
      slot_in  = slot_ff;
      limit_in = limit_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      row_in   = row_ff;
      rd_en    = 1'b0;
      rd_addr  = {slot_ff, row_ff};
      res      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               slot_in  = start_slot;
               limit_in = start_limit;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (len_sat == '0) begin
               // nothing to return: one empty closing word
               res.valid = 1'b1;
               res.last  = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               len_in   = len_sat;
               rem_in   = len_sat;
               row_in   = RW'(1);
               rd_en    = 1'b1;
               rd_addr  = {slot_ff, RW'(0)};
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            res.valid = 1'b1;
            res.bytes = take;
            res.last  = last;
            res.moved = len_ff;
            for (int b = 0; b < WORD_BYTES; b++) begin
               if (4'(b) < take) begin
                  res.data[8*b +: 8] = lane_rd_data[b];
               end
            end
            rem_in = rem_ff - 10'(take);
            if (last) begin
               state_in = ST_IDLE;
            end else begin
               rd_en  = 1'b1;
               row_in = row_ff + RW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      limit_ff <= limit_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      row_ff   <= row_in;
   end

   a_stream_has_bytes : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> (rem_ff != '0))
      else $error("pop stream running with no bytes left");

   a_start_when_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("pop started while a run is in progress");

   a_run_ends_idle : assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.last) |=> (state_ff == ST_IDLE))
      else $error("pop sequencer did not return to idle after the last word");

endmodule
`default_nettype wire

// ----- hw/rtl/packet_slot_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// packet_slot_fifo - ring of fixed-size packet slots
// Whole-packet FIFO: words pushed in, packets popped out as word runs.
// -----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low. Results come
// out on rsp_item for exactly one cycle with rsp_strobe high; there is no
// back-pressure, so the receiver must take every strobed result. Busy stays
// low during a push, so words can stream in back to back; the last word of
// a packet produces one result in the next cycle with the bytes stored (0
// when the ring was full and the packet was dropped). A pop raises busy
// while it reads the slot length memory and then streams one word per cycle
// from the byte-lane store; both memories have registered read data, and
// results are registered. A pop with nothing to return gives a single empty
// last result, and a pop of an empty queue gives it in the next cycle without
// raising busy. The store has no reset and needs no clearing pass; it is
// usable right after reset. Configuration writes are always ready and should
// only be issued while the block is idle.
// -----------------------------------------------------------------------------
module packet_slot_fifo #(
   parameter int SLOTS      = 16,
   parameter int SLOT_BYTES = 512,
   parameter int WORD_BYTES = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire pfs_pkg::pfs_req_type              req_item,
   output logic                                   rsp_strobe,
   output pfs_pkg::pfs_rsp_type                   rsp_item,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfs_pkg::CSR_DATA_W-1:0]    csr_data
);

   import pfs_pkg::*;

   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROWS  = (SLOT_BYTES + WORD_BYTES - 1) / WORD_BYTES;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW    = SW + RW;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // configuration
   logic [9:0]       slot_bytes_ff;
   logic [4:0]       slot_count_ff;

   // ring pointers
   logic [SW-1:0]    head_ff, head_in;
   logic [SW-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // result register
   logic             rsp_strobe_ff, rsp_strobe_in;
   pfs_rsp_type      rsp_item_ff, rsp_item_in;

   logic             accept;
   logic             push_acc;
   logic             pop_acc;
   logic             pop_empty;
   logic             pop_start;
   logic [CNT_W-1:0] nslots;
   logic [9:0]       limit;
   logic [CNT_W-1:0] head_plus;
   logic [CNT_W-1:0] tail_plus;

   logic                           pop_busy;
   logic                           store_rd_en;
   logic [AW-1:0]                  store_rd_addr;
   logic [WORD_BYTES-1:0][7:0]     lane_rd_data;
   logic [WORD_BYTES-1:0]          lane_we;
   logic [WORD_BYTES-1:0][AW-1:0]  lane_addr;
   logic [WORD_BYTES-1:0][7:0]     lane_data;
   logic [9:0]                     len_rd_data;
   pfs_commit_type                 commit;
   pfs_pop_res_type                pop_res;

   // ---------------------------------------------------------------------
   // Configuration port: always ready; unknown indexes are ignored.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff <= SLOT_BYTES_RST;
         slot_count_ff <= SLOT_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SLOT_BYTES) begin
            slot_bytes_ff <= csr_data;
         end else if (csr_index == CSR_SLOT_COUNT) begin
            slot_count_ff <= csr_data[4:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Effective limits and transfer decode
   // ---------------------------------------------------------------------
   always_comb begin
      // clamp the programmed values to what the storage can hold
      nslots = (9'(slot_count_ff) > 9'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slot_count_ff);
      limit  = (13'(slot_bytes_ff) > 13'(SLOT_BYTES)) ? 10'(SLOT_BYTES) : slot_bytes_ff;

      accept    = start && !busy;
      push_acc  = accept && (req_item.func == FUNC_PUSH);
      pop_acc   = accept && (req_item.func == FUNC_POP);
      pop_empty = pop_acc && (count_ff == '0);
      pop_start = pop_acc && (count_ff != '0);

      // indices wrap at the effective slot count
      head_plus = CNT_W'(head_ff) + CNT_W'(1);
      tail_plus = CNT_W'(tail_ff) + CNT_W'(1);
   end

   // ---------------------------------------------------------------------
   // Ring pointers: advance tail on a stored packet, head on a pop.
   // A push and a pop never complete in the same cycle.
   // ---------------------------------------------------------------------
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (commit.valid && commit.store) begin
         tail_in  = (tail_plus >= nslots) ? '0 : SW'(tail_plus);
         count_in = count_ff + CNT_W'(1);
      end else if (pop_start) begin
         head_in  = (head_plus >= nslots) ? '0 : SW'(head_plus);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Push writer and byte-lane store
   // ---------------------------------------------------------------------
   pfs_push #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES),
      .WORD_BYTES (WORD_BYTES)
   ) u_push (
      .clock     (clock),
      .reset     (reset),
      .accept    (push_acc),
      .req       (req_item),
      .count     (count_ff),
      .nslots    (nslots),
      .limit     (limit),
      .tail      (tail_ff),
      .lane_we   (lane_we),
      .lane_addr (lane_addr),
      .lane_data (lane_data),
      .commit    (commit)
   );

   // one memory per byte lane, so all bytes of an unaligned word land in the same cycle
   for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
      pfs_ram #(
         .WIDTH  (8),
         .ADDR_W (AW)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_we[g]),
         .wr_addr (lane_addr[g]),
         .wr_data (lane_data[g]),
         .rd_en   (store_rd_en),
         .rd_addr (store_rd_addr),
         .rd_data (lane_rd_data[g])
      );
   end

   // stored length per slot, written at commit, read when a pop starts
   pfs_ram #(
      .WIDTH  (10),
      .ADDR_W (SW)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (commit.valid && commit.store),
      .wr_addr (tail_ff),
      .wr_data (commit.length),
      .rd_en   (pop_start),
      .rd_addr (head_ff),
      .rd_data (len_rd_data)
   );

   // ---------------------------------------------------------------------
   // Pop sequencer
   // ---------------------------------------------------------------------
   pfs_pop #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES),
      .WORD_BYTES (WORD_BYTES)
   ) u_pop (
      .clock        (clock),
      .reset        (reset),
      .start        (pop_start),
      .start_slot   (head_ff),
      .start_limit  (req_item.pop_limit),
      .len_rd_data  (len_rd_data),
      .lane_rd_data (lane_rd_data),
      .busy         (pop_busy),
      .rd_en        (store_rd_en),
      .rd_addr      (store_rd_addr),
      .res          (pop_res)
   );

   assign busy = pop_busy;

   // ---------------------------------------------------------------------
   // Result register: at most one source is active in any cycle.
   // Queued always reports the count after this transfer.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_strobe_in      = pop_res.valid || commit.valid || pop_empty;
      rsp_item_in        = '0;
      rsp_item_in.queued = 5'(count_in);
      if (pop_res.valid) begin
         rsp_item_in.out_data    = pop_res.data;
         rsp_item_in.out_bytes   = pop_res.bytes;
         rsp_item_in.out_last    = pop_res.last;
         rsp_item_in.moved_bytes = pop_res.moved;
      end else if (commit.valid) begin
         rsp_item_in.out_last    = 1'b1;
         rsp_item_in.moved_bytes = commit.store ? commit.length : '0;
      end else if (pop_empty) begin
         rsp_item_in.out_last    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("queued packet count exceeds the slot count");

   a_push_last_rsp : assert property (@(posedge clock) disable iff (reset)
      (push_acc && req_item.push_last) |=>
         (rsp_strobe && rsp_item.out_last && (rsp_item.out_bytes == '0)))
      else $error("last push word did not produce its result");

   a_empty_pop_rsp : assert property (@(posedge clock) disable iff (reset)
      pop_empty |=> (rsp_strobe && rsp_item.out_last &&
                     (rsp_item.moved_bytes == '0) && (rsp_item.queued == '0)))
      else $error("pop of an empty queue did not produce an empty result");

endmodule
`default_nettype wire
